// ----- rtl/dq_pkg.sv -----
// ----------------------------------------------------------------------------
// dq_pkg: shared types and constants for the double-ended queue
// Sizes of the element store, operation codes, status codes and the
// word passed from the pointer logic to the response stage.
// ----------------------------------------------------------------------------
package dq_pkg;

	localparam int DEPTH  = 64;
	localparam int DATA_W = 32;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);

	typedef enum logic [2:0] {
		MODE_PUSH_BACK  = 3'd0,
		MODE_PUSH_FRONT = 3'd1,
		MODE_POP_FRONT  = 3'd2,
		MODE_POP_BACK   = 3'd3,
		MODE_PEEK_FRONT = 3'd4,
		MODE_PEEK_BACK  = 3'd5,
		MODE_CLEAR      = 3'd6
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// one issued operation, waiting for its store read
	typedef struct packed {
		logic             rd;
		status_t          status;
		logic [CNT_W-1:0] count;
	} issue_t;

endpackage

// ----- rtl/dq_in_if.sv -----
// ----------------------------------------------------------------------------
// dq_in_if: request channel
// Carries one operation word: mode and the value to push.
// ----------------------------------------------------------------------------
interface dq_in_if;
	logic                             valid;
	logic                             ready;
	logic [2:0]                       mode;
	logic signed [dq_pkg::DATA_W-1:0] value;

	modport source (output valid, output mode, output value, input ready);
	modport sink (input valid, input mode, input value, output ready);
endinterface

// ----- rtl/dq_out_if.sv -----
// ----------------------------------------------------------------------------
// dq_out_if: response channel
// Carries one result word: element, status and count after the operation.
// ----------------------------------------------------------------------------
interface dq_out_if;
	logic                             valid;
	logic                             ready;
	logic signed [dq_pkg::DATA_W-1:0] data;
	logic [1:0]                       status;
	logic [dq_pkg::CNT_W-1:0]         count;

	modport source (output valid, output data, output status, output count, input ready);
	modport sink (input valid, input data, input status, input count, output ready);
endinterface

// ----- rtl/dq_ram.sv -----
// ----------------------------------------------------------------------------
// dq_ram: simple dual-port synchronous RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module dq_ram #(
	parameter int WIDTH  = 32,
	parameter int DEPTH  = 64,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- rtl/dq_ctrl.sv -----
// ----------------------------------------------------------------------------
// dq_ctrl: pointer and count logic
// Decodes each accepted word, updates front pointer and fill count at once,
// and issues the store write or read for it.
// ----------------------------------------------------------------------------
module dq_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	dq_in_if.sink                       req,
	input  logic                        issue_ok,
	output logic                        iss_valid,
	output dq_pkg::issue_t              iss,
	output logic                        ram_we,
	output logic [dq_pkg::ADDR_W-1:0]   ram_waddr,
	output logic [dq_pkg::DATA_W-1:0]   ram_wdata,
	output logic                        ram_re,
	output logic [dq_pkg::ADDR_W-1:0]   ram_raddr
);
	import dq_pkg::*;

	logic [ADDR_W-1:0] front_q;
	logic [CNT_W-1:0]  fill_q;
	logic [ADDR_W-1:0] front_nxt;
	logic [CNT_W-1:0]  fill_nxt;
	logic [ADDR_W-1:0] back_addr;
	logic [ADDR_W-1:0] last_addr;
	logic [ADDR_W-1:0] prev_front;
	logic              acc;
	logic              full;
	logic              empty;
	logic              wr;
	logic              rd;
	logic [ADDR_W-1:0] waddr;
	logic [ADDR_W-1:0] raddr;
	status_t           status;

	assign req.ready = issue_ok;
	assign acc       = req.valid && req.ready;

	// ring positions, wrap by truncation
	assign full       = (fill_q == CNT_W'(DEPTH));
	assign empty      = (fill_q == '0);
	assign back_addr  = front_q + fill_q[ADDR_W-1:0];
	assign last_addr  = back_addr - ADDR_W'(1);
	assign prev_front = front_q - ADDR_W'(1);

	// operation decode
	always_comb begin
		front_nxt = front_q;
		fill_nxt  = fill_q;
		status    = ST_OK;
		wr        = 1'b0;
		rd        = 1'b0;
		waddr     = back_addr;
		raddr     = front_q;
		unique case (req.mode)
			MODE_PUSH_BACK: begin
				if (full) begin
					status = ST_FULL;
				end else begin
					wr       = 1'b1;
					fill_nxt = fill_q + CNT_W'(1);
				end
			end
			MODE_PUSH_FRONT: begin
				waddr = prev_front;
				if (full) begin
					status = ST_FULL;
				end else begin
					wr        = 1'b1;
					front_nxt = prev_front;
					fill_nxt  = fill_q + CNT_W'(1);
				end
			end
			MODE_POP_FRONT: begin
				if (empty) begin
					status = ST_EMPTY;
				end else begin
					rd        = 1'b1;
					front_nxt = front_q + ADDR_W'(1);
					fill_nxt  = fill_q - CNT_W'(1);
				end
			end
			MODE_POP_BACK: begin
				raddr = last_addr;
				if (empty) begin
					status = ST_EMPTY;
				end else begin
					rd       = 1'b1;
					fill_nxt = fill_q - CNT_W'(1);
				end
			end
			MODE_PEEK_FRONT: begin
				if (empty) begin
					status = ST_EMPTY;
				end else begin
					rd = 1'b1;
				end
			end
			MODE_PEEK_BACK: begin
				raddr = last_addr;
				if (empty) begin
					status = ST_EMPTY;
				end else begin
					rd = 1'b1;
				end
			end
			MODE_CLEAR: begin
				front_nxt = '0;
				fill_nxt  = '0;
			end
			default: begin
			end
		endcase
	end

	// pointer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			fill_q  <= '0;
		end else if (acc) begin
			front_q <= front_nxt;
			fill_q  <= fill_nxt;
		end
	end

	// store access and issued word
	assign ram_we     = acc && wr;
	assign ram_waddr  = waddr;
	assign ram_wdata  = req.value;
	assign ram_re     = acc && rd;
	assign ram_raddr  = raddr;
	assign iss_valid  = acc;
	assign iss.rd     = rd;
	assign iss.status = status;
	assign iss.count  = fill_nxt;

	// assertions
	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_W'(DEPTH))
		else $error("fill count above capacity");

	a_full_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && full && (req.mode == MODE_PUSH_BACK || req.mode == MODE_PUSH_FRONT))
		|-> !ram_we)
		else $error("store written while full");

	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && req.mode == MODE_CLEAR) |=> (fill_q == '0 && front_q == '0))
		else $error("clear did not reset pointers");

	a_no_rw: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_we && ram_re))
		else $error("read and write issued for one word");

endmodule

// ----- rtl/dq_resp.sv -----
// ----------------------------------------------------------------------------
// dq_resp: response stage
// Holds the issued word while the store read completes, then moves it with
// the read data into the output register.
// ----------------------------------------------------------------------------
module dq_resp (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      iss_valid,
	input  dq_pkg::issue_t            iss,
	input  logic [dq_pkg::DATA_W-1:0] ram_rdata,
	output logic                      issue_ok,
	dq_out_if.source                  rsp
);
	import dq_pkg::*;

	logic             v_s1;
	issue_t           iss_s1;
	logic             out_v_q;
	logic [DATA_W-1:0] data_q;
	status_t          status_q;
	logic [CNT_W-1:0] count_q;
	logic             out_load;

	assign out_load = v_s1 && (!out_v_q || rsp.ready);
	assign issue_ok = !v_s1 || out_load;

	// stage valid and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (issue_ok) begin
				v_s1 <= iss_valid;
			end
			if (out_load) begin
				out_v_q <= 1'b1;
			end else if (rsp.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (issue_ok && iss_valid) begin
			iss_s1 <= iss;
		end
		if (out_load) begin
			data_q   <= iss_s1.rd ? ram_rdata : '0;
			status_q <= iss_s1.status;
			count_q  <= iss_s1.count;
		end
	end

	assign rsp.valid  = out_v_q;
	assign rsp.data   = data_q;
	assign rsp.status = status_q;
	assign rsp.count  = count_q;

	// assertions
	a_issue_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(iss_valid && issue_ok) |=> v_s1)
		else $error("issued word lost");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && status_q == ST_FULL) |-> (count_q == CNT_W'(DEPTH)))
		else $error("full status with count below capacity");

	a_empty_word: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && status_q == ST_EMPTY) |-> (count_q == '0 && data_q == '0))
		else $error("empty status with data or count");

endmodule

// ----- rtl/double_ended_queue_core.sv -----
// ----------------------------------------------------------------------------
// double_ended_queue_core: bounded double-ended queue of signed words
// Ring buffer in a synchronous RAM; front pointer and fill count in flops.
//
//   channel  dir  handshake     payload
//   req      in   valid/ready   mode[2:0], value[31:0]
//   rsp      out  valid/ready   data[31:0], status[1:0], count[6:0]
//
// One word per cycle sustained while rsp is not stalled; the RAM read happens
// on the edge that takes the request, and the output register then loads the
// read data and issued word from the read stage when the output is free.
// Pointers update when the request is taken, so a read of an entry written
// by the previous word sees the new data through the RAM write port.
// Reset clears pointers and valids; RAM contents are left unknown.
// A stalled rsp holds one word in the output register and one in the read
// stage before req.ready drops.
// ----------------------------------------------------------------------------
module double_ended_queue_core (
	input logic       clk,
	input logic       arst_n,
	dq_in_if.sink     req,
	dq_out_if.source  rsp
);
	import dq_pkg::*;

	logic              issue_ok;
	logic              iss_valid;
	issue_t            iss;
	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [DATA_W-1:0] ram_wdata;
	logic              ram_re;
	logic [ADDR_W-1:0] ram_raddr;
	logic [DATA_W-1:0] ram_rdata;

	dq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.issue_ok  (issue_ok),
		.iss_valid (iss_valid),
		.iss       (iss),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr)
	);

	dq_ram #(
		.WIDTH (DATA_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	dq_resp u_resp (
		.clk       (clk),
		.arst_n    (arst_n),
		.iss_valid (iss_valid),
		.iss       (iss),
		.ram_rdata (ram_rdata),
		.issue_ok  (issue_ok),
		.rsp       (rsp)
	);

endmodule
